// ===== src/bfb_pkg.sv =====
// shared types and constants for the bmp framebuffer blitter
package bfb_pkg;

	localparam int unsigned FB_WIDTH  = 800;
	localparam int unsigned FB_HEIGHT = 480;

	localparam int unsigned WIDTH_W  = 10;
	localparam int unsigned HEIGHT_W = 9;
	localparam int unsigned ADDR_W   = 19;
	localparam int unsigned COLOR_W  = 24;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_MODE  = 3'd4;

	typedef enum logic [1:0] {
		LAYOUT_PLAIN = 2'd0,
		LAYOUT_MID   = 2'd1,
		LAYOUT_LEFT  = 2'd2,
		LAYOUT_RIGHT = 2'd3
	} layout_t;

	// image size already forced to at least one
	typedef struct packed {
		logic [WIDTH_W-1:0]  width;
		logic [HEIGHT_W-1:0] height;
		logic [WIDTH_W-1:0]  origin_x;
		logic [HEIGHT_W-1:0] origin_y;
		layout_t             mode;
	} cfg_t;

	typedef struct packed {
		logic [WIDTH_W-1:0]  column;
		logic [HEIGHT_W-1:0] file_row;
	} pos_t;

endpackage

// ===== src/bfb_cfg_regs.sv =====
// configuration register file of the blitter
module bfb_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [bfb_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [bfb_pkg::CFG_DATA_W-1:0] wr_data,
	output bfb_pkg::cfg_t                  cfg
);
	import bfb_pkg::*;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [WIDTH_W-1:0]  origin_x_q;
	logic [HEIGHT_W-1:0] origin_y_q;
	layout_t             mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= WIDTH_W'(FB_WIDTH);
			height_q   <= HEIGHT_W'(FB_HEIGHT);
			origin_x_q <= '0;
			origin_y_q <= '0;
			mode_q     <= LAYOUT_PLAIN;
		end else if (wr_en) begin
			case (wr_index)
				REG_IMAGE_WIDTH:  width_q    <= wr_data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: height_q   <= wr_data[HEIGHT_W-1:0];
				REG_ORIGIN_X:     origin_x_q <= wr_data[WIDTH_W-1:0];
				REG_ORIGIN_Y:     origin_y_q <= wr_data[HEIGHT_W-1:0];
				REG_LAYOUT_MODE:  mode_q     <= layout_t'(wr_data[1:0]);
				default: begin
				end
			endcase
		end
	end

	// a zero size behaves as one
	always_comb begin
		cfg.width    = (width_q == '0) ? WIDTH_W'(1) : width_q;
		cfg.height   = (height_q == '0) ? HEIGHT_W'(1) : height_q;
		cfg.origin_x = origin_x_q;
		cfg.origin_y = origin_y_q;
		cfg.mode     = mode_q;
	end

endmodule

// ===== src/bfb_pos_track.sv =====
// column and file row counters of the incoming bitmap
module bfb_pos_track (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  bfb_pkg::cfg_t cfg,
	output bfb_pkg::pos_t pos
);
	import bfb_pkg::*;

	logic [WIDTH_W-1:0]  column_q;
	logic [HEIGHT_W-1:0] file_row_q;
	logic [WIDTH_W:0]    column_inc;
	logic [HEIGHT_W:0]   row_inc;

	assign column_inc = {1'b0, column_q} + (WIDTH_W+1)'(1);
	assign row_inc    = {1'b0, file_row_q} + (HEIGHT_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q   <= '0;
			file_row_q <= '0;
		end else if (advance) begin
			if (column_inc >= {1'b0, cfg.width}) begin
				column_q <= '0;
				if (row_inc >= {1'b0, cfg.height}) begin
					file_row_q <= '0;
				end else begin
					file_row_q <= row_inc[HEIGHT_W-1:0];
				end
			end else begin
				column_q <= column_inc[WIDTH_W-1:0];
			end
		end
	end

	assign pos.column   = column_q;
	assign pos.file_row = file_row_q;

endmodule

// ===== src/bfb_layout_map.sv =====
// layout selection, screen clipping and framebuffer address
module bfb_layout_map (
	input  bfb_pkg::cfg_t                cfg,
	input  bfb_pkg::pos_t                pos,
	output logic                         keep,
	output logic [bfb_pkg::ADDR_W-1:0]   address
);
	import bfb_pkg::*;

	logic                   in_image;
	logic [HEIGHT_W-1:0]    disp_row;
	logic [WIDTH_W-4:0]     eighth;
	logic [HEIGHT_W-1:0]    span;
	logic                   row_ok;
	logic [WIDTH_W-1:0]     crop_col;
	logic                   layout_keep;
	logic [WIDTH_W-1:0]     dx;
	logic [HEIGHT_W-1:0]    dy;
	logic [WIDTH_W:0]       scr_x;
	logic [HEIGHT_W:0]      scr_y;

	always_comb begin
		in_image = (pos.column < cfg.width) && (pos.file_row < cfg.height);
		disp_row = cfg.height - HEIGHT_W'(1) - pos.file_row;
		eighth   = cfg.width[WIDTH_W-1:3];
		span     = HEIGHT_W'(eighth) * HEIGHT_W'(3);
		row_ok   = !disp_row[0] && (disp_row[HEIGHT_W-1:1] < cfg.height[HEIGHT_W-1:1]);
		crop_col = pos.column - WIDTH_W'(eighth);

		layout_keep = 1'b0;
		dx = {1'b0, pos.column[WIDTH_W-1:1]};
		dy = {1'b0, disp_row[HEIGHT_W-1:1]};
		case (cfg.mode)
			LAYOUT_PLAIN: begin
				layout_keep = 1'b1;
				dx = pos.column;
				dy = disp_row;
			end
			LAYOUT_MID: begin
				layout_keep = row_ok && !pos.column[0]
					&& (pos.column[WIDTH_W-1:1] < cfg.width[WIDTH_W-1:1]);
			end
			LAYOUT_LEFT: begin
				// crop window starts one eighth of the width in
				dx = {1'b0, crop_col[WIDTH_W-1:1]};
				layout_keep = (pos.column >= WIDTH_W'(eighth)) && row_ok
					&& !crop_col[0] && (crop_col[WIDTH_W-1:1] < span);
			end
			LAYOUT_RIGHT: begin
				layout_keep = row_ok && !pos.column[0]
					&& (pos.column[WIDTH_W-1:1] < span);
			end
			default: begin
				layout_keep = 1'b0;
			end
		endcase

		scr_x = {1'b0, cfg.origin_x} + {1'b0, dx};
		scr_y = {1'b0, cfg.origin_y} + {1'b0, dy};
		keep  = in_image && layout_keep
			&& (scr_x < (WIDTH_W+1)'(FB_WIDTH)) && (scr_y < (HEIGHT_W+1)'(FB_HEIGHT));
		address = ADDR_W'(scr_y) * ADDR_W'(FB_WIDTH) + ADDR_W'(scr_x);
	end

endmodule

// ===== src/bmp_framebuffer_blitter_core.sv =====
// top level of the bmp to framebuffer blitter
//
//  channel | direction | handshake          | content
//  s_*     | in        | s_tvalid/s_tready  | one bgr pixel of the bitmap per beat
//  m_*     | out       | m_tvalid/m_tready  | one framebuffer write per beat
//  cfg_*   | in        | cfg_valid/cfg_ready| register index and write data
//
// one pixel per clock sustained while m_tready does not stall; a beat goes to m_* through
// the input register, then layout/address logic into the result register
// pixels that the layout drops or that fall off screen give no output beat
// arst_n clears the counters and stage valids and sets the config registers to their defaults
// a stall on m_tready holds the result; the input register still fills behind it
module bmp_framebuffer_blitter_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// bits 7:0 pixel_blue, 15:8 pixel_green, 23:16 pixel_red
	input  logic [23:0]                    s_tdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// bits 18:0 fb_address, 42:19 fb_color, 47:43 zero
	output logic [47:0]                    m_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bfb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bfb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bfb_pkg::*;

	cfg_t cfg;
	pos_t pos;

	// input register
	logic               valid_s1;
	pos_t               pos_s1;
	logic [COLOR_W-1:0] color_s1;

	// result register
	logic               valid_s2;
	logic [ADDR_W-1:0]  address_s2;
	logic [COLOR_W-1:0] color_s2;

	logic              accept;
	logic              adv_s1;
	logic              adv_s2;
	logic              keep;
	logic [ADDR_W-1:0] address;

	// result register may load when empty or being drained
	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;
	assign accept   = s_tvalid && s_tready;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	bfb_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	bfb_pos_track u_pos (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.cfg     (cfg),
		.pos     (pos)
	);

	bfb_layout_map u_map (
		.cfg     (cfg),
		.pos     (pos_s1),
		.keep    (keep),
		.address (address)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= accept;
		end
	end

	// payload of the input register, packed red/green/blue
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1   <= pos;
			color_s1 <= {s_tdata[23:16], s_tdata[15:8], s_tdata[7:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1 && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			address_s2 <= address;
			color_s2   <= color_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b0, color_s2, address_s2};

endmodule

// ===== tb/tb_bmp_framebuffer_blitter_core.sv =====
// self-checking testbench for the bmp to framebuffer blitter core
module tb_bmp_framebuffer_blitter_core;
	timeunit 1ns;
	timeprecision 1ps;

	import bfb_pkg::*;

	// cycles the block may still be busy after the last write came out (two stages plus margin)
	localparam int unsigned SETTLE_CYCLES = 8;
	// watchdog in clock cycles
	localparam int unsigned RUN_LIMIT     = 400000;
	// length of the one long receiver hold-off
	localparam int unsigned LONG_HOLD     = 300;
	// pixels the random part aims for
	localparam int unsigned RANDOM_PIXELS = 1100;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] color;
	} fb_write_t;

	// receiver stall patterns
	typedef enum int unsigned {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_BEAT_SKIP
	} rx_style_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic [23:0]           s_tdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [47:0]           m_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// shadow of the register file and the pixel counters
	logic [WIDTH_W-1:0]  img_w;
	logic [HEIGHT_W-1:0] img_h;
	logic [WIDTH_W-1:0]  org_x;
	logic [HEIGHT_W-1:0] org_y;
	layout_t             lay_mode;
	logic [WIDTH_W-1:0]  pix_col;
	logic [HEIGHT_W-1:0] pix_row;

	// framebuffer writes still owed by the block, oldest first
	fb_write_t due_writes[$];

	int unsigned mismatches   = 0;
	int unsigned pixels_sent  = 0;
	int unsigned hold_asks    = 0;
	int unsigned burst_left   = 0;
	bit          gaps_on      = 1'b1;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	bmp_framebuffer_blitter_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// work out where one pixel lands, if anywhere, and step the counters
	function automatic bit place_pixel(input logic [23:0] bgr, output fb_write_t wr);
		int unsigned w, h, col, frow, r, eighth, span, c, dx, dy, x, y;
		bit keep, row_ok;
		wr     = '0;
		// a zero size behaves as one
		w      = (img_w == 0) ? 1 : img_w;
		h      = (img_h == 0) ? 1 : img_h;
		col    = pix_col;
		frow   = pix_row;
		keep   = 1'b0;
		dx     = 0;
		dy     = 0;
		if (col < w && frow < h) begin
			// bitmaps are stored bottom row first
			r      = h - 1 - frow;
			eighth = w / 8;
			span   = eighth * 3;
			row_ok = (r % 2 == 0) && (r / 2 < h / 2);
			case (lay_mode)
				LAYOUT_PLAIN: begin
					keep = 1'b1;
					dx   = col;
					dy   = r;
				end
				LAYOUT_MID: begin
					keep = row_ok && (col % 2 == 0) && (col / 2 < w / 2);
					dx   = col / 2;
					dy   = r / 2;
				end
				LAYOUT_LEFT: begin
					if (col >= eighth) begin
						c    = col - eighth;
						keep = row_ok && (c % 2 == 0) && (c / 2 < span);
						dx   = c / 2;
						dy   = r / 2;
					end
				end
				default: begin
					keep = row_ok && (col % 2 == 0) && (col / 2 < span);
					dx   = col / 2;
					dy   = r / 2;
				end
			endcase
		end
		// counters outside the image wrap just as at a row end
		if (col + 1 >= w) begin
			pix_col = '0;
			pix_row = (frow + 1 >= h) ? '0 : HEIGHT_W'(frow + 1);
		end else begin
			pix_col = WIDTH_W'(col + 1);
		end
		if (!keep)
			return 1'b0;
		x = org_x + dx;
		y = org_y + dy;
		if (x >= FB_WIDTH || y >= FB_HEIGHT)
			return 1'b0;
		wr.addr  = ADDR_W'(y * FB_WIDTH + x);
		wr.color = {bgr[23:16], bgr[15:8], bgr[7:0]};
		return 1'b1;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_IMAGE_WIDTH:  img_w    = val[WIDTH_W-1:0];
			REG_IMAGE_HEIGHT: img_h    = val[HEIGHT_W-1:0];
			REG_ORIGIN_X:     org_x    = val[WIDTH_W-1:0];
			REG_ORIGIN_Y:     org_y    = val[HEIGHT_W-1:0];
			REG_LAYOUT_MODE:  lay_mode = layout_t'(val[1:0]);
			default: ;
		endcase
	endfunction

	// hold the input back until every owed write is out and the pipe is empty
	task automatic drain_writes();
		s_tvalid <= 1'b0;
		while (due_writes.size() != 0)
			@(posedge clk);
		// a dropped pixel may still be in flight behind the last write
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all five registers while the block is idle
	task automatic set_blit(input int unsigned w, input int unsigned h, input int unsigned ox,
			input int unsigned oy, input layout_t mode);
		logic [CFG_IDX_W-1:0]  idxs [5];
		logic [CFG_DATA_W-1:0] vals [5];
		drain_writes();
		idxs[0] = REG_IMAGE_WIDTH;  vals[0] = CFG_DATA_W'(w);
		idxs[1] = REG_IMAGE_HEIGHT; vals[1] = CFG_DATA_W'(h);
		idxs[2] = REG_ORIGIN_X;     vals[2] = CFG_DATA_W'(ox);
		idxs[3] = REG_ORIGIN_Y;     vals[3] = CFG_DATA_W'(oy);
		idxs[4] = REG_LAYOUT_MODE;  vals[4] = CFG_DATA_W'(mode);
		for (int i = 0; i < 5; i++) begin
			cfg_index <= idxs[i];
			cfg_data  <= vals[i];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
			apply_reg(idxs[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// offer one pixel beat, bursts and gaps decided here
	task automatic push_pixel(input logic [23:0] bgr);
		fb_write_t wr;
		int unsigned gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		s_tdata  <= bgr;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pixels_sent++;
		if (burst_left > 0)
			burst_left--;
		if (place_pixel(bgr, wr))
			due_writes.push_back(wr);
	endtask

	// pixel extremes, zero size, off screen on both axes
	task automatic test_corner_pixels();
		gaps_on = 1'b0;
		// zero width and height act as a one pixel image, always at the origin
		set_blit(0, 0, 0, 0, LAYOUT_PLAIN);
		push_pixel(24'h000000);
		push_pixel(24'hFFFFFF);
		// 3x2 image in the bottom right corner: bottom row below the screen, last column past it
		set_blit(3, 2, 798, 479, LAYOUT_PLAIN);
		push_pixel(24'h0000FF);
		push_pixel(24'h00FF00);
		push_pixel(24'hFF0000);
		push_pixel(24'h123456);
		push_pixel(24'hA5C3E1);
		push_pixel(24'h5A3C1E);
	endtask

	// thumbnail layouts on odd sizes, then a size change in mid image
	task automatic test_thumbnail_edges();
		gaps_on = 1'b1;
		// odd width: last column has no partner and is dropped
		set_blit(3, 2, 0, 0, LAYOUT_MID);
		repeat (6) push_pixel(24'($urandom()));
		// left crop: skips w/8 columns then keeps every other one for 3w/8
		set_blit(8, 2, 10, 5, LAYOUT_LEFT);
		repeat (14) push_pixel(24'($urandom()));
		// counters now sit past the new width: first pixel dropped, counters wrap
		set_blit(2, 1, 400, 240, LAYOUT_PLAIN);
		push_pixel(24'($urandom()));
		push_pixel(24'($urandom()));
	endtask

	// random sizes, placements and layouts, mostly whole images
	task automatic test_random_layouts();
		int unsigned w, h, ox, oy, n, we, he, pos, big_left, target;
		layout_t mode;
		big_left = 2;
		target   = pixels_sent + RANDOM_PIXELS;
		while (pixels_sent < target) begin
			w = $urandom_range(1, 24);
			h = $urandom_range(1, 12);
			if (big_left > 0 && $urandom_range(0, 15) == 0) begin
				// a wide image, sent for at most two rows of pixels
				big_left--;
				w = $urandom_range(512, 800);
				h = $urandom_range(1, 3);
			end else if ($urandom_range(0, 9) == 0) begin
				// a tall narrow one
				w = $urandom_range(1, 3);
				h = $urandom_range(256, 480);
			end else if ($urandom_range(0, 19) == 0) begin
				w = 0;
			end else if ($urandom_range(0, 19) == 0) begin
				h = 0;
			end
			case ($urandom_range(0, 3))
				0: begin
					ox = 0;
					oy = 0;
				end
				1: begin
					ox = 799;
					oy = 479;
				end
				2: begin
					ox = $urandom_range(770, 799);
					oy = $urandom_range(450, 479);
				end
				default: begin
					ox = $urandom_range(0, 799);
					oy = $urandom_range(0, 479);
				end
			endcase
			mode    = layout_t'($urandom_range(0, 3));
			gaps_on = ($urandom_range(0, 3) != 0);
			set_blit(w, h, ox, oy, mode);
			we = (w == 0) ? 1 : w;
			he = (h == 0) ? 1 : h;
			if (we * he <= 400 && $urandom_range(0, 3) != 0) begin
				// finish the current image, then whole images
				pos = (pix_col < we && pix_row < he) ? pix_row * we + pix_col : 0;
				n   = we * he - pos + we * he * $urandom_range(0, 2);
			end else if (we * he > 400) begin
				n = $urandom_range(1, 2 * we);
			end else begin
				// broken run
				n = $urandom_range(1, 60);
			end
			// keep the run near its pixel budget
			if (n > target - pixels_sent)
				n = target - pixels_sent;
			repeat (n) push_pixel(24'($urandom()));
		end
	endtask

	// long receiver hold-off with the sender pushing, then a full pause
	task automatic test_output_backpressure();
		gaps_on = 1'b0;
		set_blit(16, 8, 100, 50, LAYOUT_PLAIN);
		hold_asks++;
		repeat (120) push_pixel(24'($urandom()));
		// sender waits for every owed write before going on
		drain_writes();
		gaps_on = 1'b1;
		repeat (40) push_pixel(24'($urandom()));
	endtask

	// receiver: stall patterns in segments, plus the long hold-off on request
	initial begin : rx_side
		rx_style_t   style;
		int unsigned seg_left, hold_left, holds_taken, beat_no;
		style       = RX_OPEN;
		seg_left    = 0;
		hold_left   = 0;
		holds_taken = 0;
		beat_no     = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asks != holds_taken) begin
				holds_taken = hold_asks;
				hold_left   = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					style    = rx_style_t'($urandom_range(0, 3));
					seg_left = $urandom_range(20, 300);
				end
				seg_left--;
				beat_no++;
				case (style)
					RX_OPEN:      m_tready <= 1'b1;
					RX_COIN:      m_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE:    m_tready <= ($urandom_range(0, 9) != 0);
					default:      m_tready <= (beat_no % 5 != 0);
				endcase
			end
		end
	end

	// compare every output beat with the oldest owed write
	always @(posedge clk) begin
		fb_write_t due;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_writes.size() == 0) begin
				$display("%0t unexpected write: expected none, actual addr %h color %h",
					$time, m_tdata[18:0], m_tdata[42:19]);
				mismatches++;
			end else begin
				due = due_writes.pop_front();
				if (m_tdata[18:0] !== due.addr) begin
					$display("%0t fb_address: expected %h, actual %h",
						$time, due.addr, m_tdata[18:0]);
					mismatches++;
				end
				if (m_tdata[42:19] !== due.color) begin
					$display("%0t fb_color: expected %h, actual %h",
						$time, due.color, m_tdata[42:19]);
					mismatches++;
				end
				if (m_tdata[47:43] !== 5'd0) begin
					$display("%0t padding: expected %h, actual %h",
						$time, 5'd0, m_tdata[47:43]);
					mismatches++;
				end
			end
		end
	end

	// cycle watchdog
	initial begin : watchdog
		int unsigned cycles;
		for (cycles = 0; cycles < RUN_LIMIT; cycles++)
			@(posedge clk);
		$display("[bmp_framebuffer_blitter_core] ERROR");
		$finish;
	end

	initial begin : main_seq
		int unsigned waited;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data  <= '0;
		// register and counter defaults after reset
		img_w    = WIDTH_W'(FB_WIDTH);
		img_h    = HEIGHT_W'(FB_HEIGHT);
		org_x    = '0;
		org_y    = '0;
		lay_mode = LAYOUT_PLAIN;
		pix_col  = '0;
		pix_row  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_pixels();
		test_thumbnail_edges();
		test_random_layouts();
		test_output_backpressure();

		// let the last writes drain, bounded
		s_tvalid <= 1'b0;
		for (waited = 0; waited < 4000 && due_writes.size() != 0; waited++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (due_writes.size() != 0) begin
			$display("%0t missing writes: expected addr %h color %h, actual none (%0d owed)",
				$time, due_writes[0].addr, due_writes[0].color, due_writes.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("[bmp_framebuffer_blitter_core] OK");
		else
			$display("[bmp_framebuffer_blitter_core] ERROR");
		$finish;
	end

endmodule
